FILE: hdl/bsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Shared types, register decode codes and reset values for the mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

   // CPU write address decode (addr & ADDR_MASK)
   localparam logic [15:0] ADDR_MASK        = 16'hE001;
   localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
   localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

   // Bank select target codes (select bits 2..0)
   localparam logic [2:0] SEL_CHR0 = 3'd0;
   localparam logic [2:0] SEL_CHR1 = 3'd1;
   localparam logic [2:0] SEL_CHR2 = 3'd2;
   localparam logic [2:0] SEL_CHR3 = 3'd3;
   localparam logic [2:0] SEL_CHR4 = 3'd4;
   localparam logic [2:0] SEL_CHR5 = 3'd5;
   localparam logic [2:0] SEL_PRG0 = 3'd6;
   localparam logic [2:0] SEL_PRG1 = 3'd7;

   localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;
   localparam logic [8:0] SCANLINE_LAST = 9'd239;

   // Input request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRG_BANK_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHR_ROM_PRESENT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOUR_SCREEN     = 2'd2;
   localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd16;

   typedef struct packed {
      logic        mode;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [8:0]  scanline;
      logic        render_on;
   } item_type;

   typedef struct packed {
      logic [7:0]      bank_select;
      logic [5:0][7:0] chr_bank;
      logic [1:0][7:0] prg_bank;
      logic [7:0]      irq_count;
      logic [7:0]      irq_reload;
      logic            irq_on;
      logic            mirror;
   } state_type;

   localparam state_type STATE_RESET = '{
      bank_select: 8'd0,
      chr_bank:    {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0},
      prg_bank:    {8'd1, 8'd0},
      irq_count:   8'd0,
      irq_reload:  8'd0,
      irq_on:      1'b0,
      mirror:      1'b0
   };

endpackage

FILE: hdl/bsm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mapper register file
// Decodes CPU writes and scanline ticks, holds the bank and IRQ state.
// ----------------------------------------------------------------------------
module bsm_regs (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  bsm_pkg::item_type   item,
   input  logic                four_screen,
   output bsm_pkg::state_type  state_next,
   output logic                irq_pulse
);

   bsm_pkg::state_type state_ff;
   bsm_pkg::state_type state_in;
   logic [2:0]         sel;
   logic               tick_live;

   assign sel = state_ff.bank_select[2:0];
   assign tick_live = state_ff.irq_on && (item.scanline <= bsm_pkg::SCANLINE_LAST)
                      && item.render_on;

   always_comb begin
      state_in  = state_ff;
      irq_pulse = 1'b0;
      if (item.mode == bsm_pkg::MODE_WRITE) begin
         unique case (item.addr & bsm_pkg::ADDR_MASK)
            bsm_pkg::ADDR_BANK_SELECT: state_in.bank_select = item.data;
            bsm_pkg::ADDR_BANK_DATA: begin
               case (sel) inside
                  bsm_pkg::SEL_CHR0, bsm_pkg::SEL_CHR1:
                     state_in.chr_bank[sel] = item.data & bsm_pkg::CHR_PAIR_MASK;
                  bsm_pkg::SEL_CHR2, bsm_pkg::SEL_CHR3,
                  bsm_pkg::SEL_CHR4, bsm_pkg::SEL_CHR5:
                     state_in.chr_bank[sel] = item.data;
                  default: state_in.prg_bank[sel[0]] = item.data;
               endcase
            end
            bsm_pkg::ADDR_MIRROR: begin
               if (!four_screen) begin
                  state_in.mirror = item.data[0];
               end
            end
            bsm_pkg::ADDR_IRQ_COUNT:   state_in.irq_count  = item.data;
            bsm_pkg::ADDR_IRQ_RELOAD:  state_in.irq_reload = item.data;
            bsm_pkg::ADDR_IRQ_DISABLE: state_in.irq_on     = 1'b0;
            bsm_pkg::ADDR_IRQ_ENABLE:  state_in.irq_on     = 1'b1;
            default: ;
         endcase
      end else if (tick_live) begin
         if (state_ff.irq_count == 8'd0) begin
            state_in.irq_count = state_ff.irq_reload;
            irq_pulse          = 1'b1;
         end else begin
            state_in.irq_count = state_ff.irq_count - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsm_pkg::STATE_RESET;
      end else if (item_valid) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule

FILE: hdl/bsm_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mapper bank map packer
// Builds the program and character slot maps from the bank registers.
// ----------------------------------------------------------------------------
module bsm_pack (
   input  bsm_pkg::state_type state,
   input  logic [8:0]         prg_bank_count,
   output logic [31:0]        prg_map,
   output logic [63:0]        chr_map
);

   logic [7:0]  second_last;
   logic [7:0]  last;
   logic [31:0] pairs;
   logic [31:0] singles;

   // fixed banks wrap modulo 256
   assign second_last = prg_bank_count[7:0] - 8'd2;
   assign last        = prg_bank_count[7:0] - 8'd1;

   assign pairs = {state.chr_bank[1] + 8'd1, state.chr_bank[1],
                   state.chr_bank[0] + 8'd1, state.chr_bank[0]};
   assign singles = {state.chr_bank[5], state.chr_bank[4],
                     state.chr_bank[3], state.chr_bank[2]};

   always_comb begin
      if (state.bank_select[6]) begin
         prg_map = {last, state.prg_bank[0], state.prg_bank[1], second_last};
      end else begin
         prg_map = {last, second_last, state.prg_bank[1], state.prg_bank[0]};
      end
      if (state.bank_select[7]) begin
         chr_map = {pairs, singles};
      end else begin
         chr_map = {singles, pairs};
      end
   end

endmodule

FILE: hdl/bank_switch_mapper_scanline_irq_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper with scanline IRQ counter
// CPU writes and scanline ticks update the mapper state; each request returns
// the packed bank maps, mirroring and the IRQ pulse.
// Path: each request goes through the input register, then the result register;
//   one request per cycle while the response side does not stall.
// The rate is set by the single register-file update between the two stages.
// Reset (synchronous, active high) restores bank, IRQ and config defaults and
//   empties both stages.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   input  logic [8:0]  req_scanline,
   input  logic        req_render_on,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_irq_pulse,
   output logic        rsp_mirror_horizontal,
   output logic [31:0] rsp_prg_map,
   output logic [63:0] rsp_chr_map,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [8:0]  csr_data
);

   bsm_pkg::item_type  item_ff;
   logic               item_valid_ff;
   logic               advance;
   logic               fire;
   bsm_pkg::state_type state_next;
   logic               irq_pulse;
   logic [31:0]        prg_map;
   logic [63:0]        chr_map;
   logic [8:0]         prg_bank_count_ff;
   logic               four_screen_ff;
   logic               rsp_valid_ff;
   logic               rsp_irq_pulse_ff;
   logic               rsp_mirror_ff;
   logic [31:0]        rsp_prg_map_ff;
   logic [63:0]        rsp_chr_map_ff;

   // Advance the input stage whenever the result register is empty or drains.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid_ff && advance;
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Input register: hold the request until the result register can take it.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         item_ff <= '{mode: req_mode, addr: req_addr, data: req_data,
                      scanline: req_scanline, render_on: req_render_on};
      end
   end

   // Configuration registers. Character ROM vs RAM selection does not change
   // the reported bank numbers, so that write is taken and dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= bsm_pkg::PRG_BANK_COUNT_RESET;
         four_screen_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsm_pkg::CSR_PRG_BANK_COUNT:  prg_bank_count_ff <= csr_data;
            bsm_pkg::CSR_FOUR_SCREEN:     four_screen_ff    <= csr_data[0];
            bsm_pkg::CSR_CHR_ROM_PRESENT: ;
            default: ;
         endcase
      end
   end

   // Register file: commit the decoded update as the request moves on.
   bsm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (fire),
      .item        (item_ff),
      .four_screen (four_screen_ff),
      .state_next  (state_next),
      .irq_pulse   (irq_pulse)
   );

   // Maps reflect the state after this request's update.
   bsm_pack u_pack (
      .state          (state_next),
      .prg_bank_count (prg_bank_count_ff),
      .prg_map        (prg_map),
      .chr_map        (chr_map)
   );

   // Result register: hold the response until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
      if (fire) begin
         rsp_irq_pulse_ff <= irq_pulse;
         rsp_mirror_ff    <= state_next.mirror;
         rsp_prg_map_ff   <= prg_map;
         rsp_chr_map_ff   <= chr_map;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_irq_pulse         = rsp_irq_pulse_ff;
   assign rsp_mirror_horizontal = rsp_mirror_ff;
   assign rsp_prg_map           = rsp_prg_map_ff;
   assign rsp_chr_map           = rsp_chr_map_ff;

   // Request side stalls only while a request sits in the input stage.
   a_ready_low_only_when_full : assert property (
      @(posedge clock) disable iff (reset) !req_ready |-> item_valid_ff)
      else $error("request stall with empty input stage");

   // Both stages come out of reset empty.
   a_empty_after_reset : assert property (
      @(posedge clock) $past(reset) |-> (!rsp_valid_ff && !item_valid_ff))
      else $error("pipeline not empty after reset");

   // Last program slot is always the fixed last bank.
   a_last_bank_fixed : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_prg_map_ff[31:24] == prg_bank_count_ff[7:0] - 8'd1))
      else $error("last program slot not fixed");

   // A pulse always reloads the counter from the latch.
   a_pulse_reloads : assert property (
      @(posedge clock) disable iff (reset)
      (fire && irq_pulse) |-> (state_next.irq_count == state_next.irq_reload))
      else $error("irq pulse without counter reload");

endmodule

FILE: dv/bank_switch_mapper_scanline_irq_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper testbench
// Drives CPU writes and scanline ticks into the mapper, tracks the bank, IRQ
// and mirroring state alongside it and checks every response in order. The run
// opens with a directed sequence and then steps through several mapper
// configurations with random traffic, random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_unit_tb;

   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned RANDOM_PER_PHASE = 163;
   localparam int unsigned PHASE_COUNT      = 6;
   localparam int unsigned HOLD_AFTER_RSP   = 250;
   localparam int unsigned HOLD_CYCLES      = 400;
   localparam int unsigned MAX_PRINTED      = 100;

   // Address bits the decoder ignores; OR them in to hit register aliases
   localparam logic [15:0] ALIAS_BITS       = 16'h1FFE;
   // Odd mirroring address: not decoded to any register, so writes nothing
   localparam logic [15:0] ADDR_MIRROR_NOP  = bsm_pkg::ADDR_MIRROR | 16'h0001;
   // Index with no register behind it
   localparam logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // Bank count per configuration phase; phase 0 runs on reset values and
   // the last phase draws its own
   localparam logic [8:0] PHASE_BANK_COUNT [PHASE_COUNT] =
      '{9'd16, 9'd2, 9'd256, 9'd0, 9'd511, 9'd1};
   localparam logic PHASE_FOUR_SCREEN [PHASE_COUNT] =
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

   typedef enum int unsigned {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_MOSTLY
   } rx_style_type;

   typedef struct {
      logic        irq_pulse;
      logic        mirror_horizontal;
      logic [31:0] prg_map;
      logic [63:0] chr_map;
   } bank_maps_type;

   // -------------------------------------------------------------------------
   // Shadow of the mapper: configuration, bank and IRQ state, and the queue
   // of bank maps still owed by the block.
   // -------------------------------------------------------------------------
   class bank_map_scoreboard_type;
      logic [8:0]    prg_bank_count;
      logic          chr_rom_present;
      logic          four_screen;
      logic [7:0]    bank_select;
      logic [7:0]    chr_bank [6];
      logic [7:0]    prg_bank [2];
      logic [7:0]    irq_count;
      logic [7:0]    irq_reload;
      logic          irq_on;
      logic          mirror;
      bank_maps_type expected_maps [$];
      int unsigned   mismatches;
      int unsigned   checked;

      function new();
         prg_bank_count  = 9'd16;
         chr_rom_present = 1'b1;
         four_screen     = 1'b0;
         bank_select     = 8'd0;
         chr_bank        = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};
         prg_bank        = '{8'd0, 8'd1};
         irq_count       = 8'd0;
         irq_reload      = 8'd0;
         irq_on          = 1'b0;
         mirror          = 1'b0;
         mismatches      = 0;
         checked         = 0;
      endfunction

      function void write_config(logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [8:0] value);
         case (index)
            bsm_pkg::CSR_PRG_BANK_COUNT:  prg_bank_count  = value;
            bsm_pkg::CSR_CHR_ROM_PRESENT: chr_rom_present = value[0];
            bsm_pkg::CSR_FOUR_SCREEN:     four_screen     = value[0];
            default: ;
         endcase
      endfunction

      function void note_request(bsm_pkg::item_type req);
         bank_maps_type want;
         logic [8:0]    second_last;
         logic [8:0]    last_bank;
         logic [7:0]    slot0;
         logic [7:0]    slot2;
         logic [31:0]   pairs;
         logic [31:0]   singles;

         want.irq_pulse = 1'b0;
         if (req.mode == bsm_pkg::MODE_WRITE) begin
            case (req.addr & bsm_pkg::ADDR_MASK)
               bsm_pkg::ADDR_BANK_SELECT: bank_select = req.data;
               bsm_pkg::ADDR_BANK_DATA: begin
                  case (bank_select[2:0])
                     bsm_pkg::SEL_CHR0, bsm_pkg::SEL_CHR1:
                        chr_bank[bank_select[2:0]] = req.data & bsm_pkg::CHR_PAIR_MASK;
                     bsm_pkg::SEL_PRG0: prg_bank[0] = req.data;
                     bsm_pkg::SEL_PRG1: prg_bank[1] = req.data;
                     default:           chr_bank[bank_select[2:0]] = req.data;
                  endcase
               end
               bsm_pkg::ADDR_MIRROR:      if (!four_screen) mirror = req.data[0];
               bsm_pkg::ADDR_IRQ_COUNT:   irq_count  = req.data;
               bsm_pkg::ADDR_IRQ_RELOAD:  irq_reload = req.data;
               bsm_pkg::ADDR_IRQ_DISABLE: irq_on     = 1'b0;
               bsm_pkg::ADDR_IRQ_ENABLE:  irq_on     = 1'b1;
               default: ;
            endcase
         end else if (irq_on && req.scanline <= bsm_pkg::SCANLINE_LAST && req.render_on) begin
            // expired counter reloads and fires, otherwise count down
            if (irq_count == 8'd0) begin
               irq_count      = irq_reload;
               want.irq_pulse = 1'b1;
            end else begin
               irq_count = irq_count - 8'd1;
            end
         end

         // fixed banks wrap modulo 256
         second_last = prg_bank_count - 9'd2;
         last_bank   = prg_bank_count - 9'd1;
         slot0 = bank_select[6] ? second_last[7:0] : prg_bank[0];
         slot2 = bank_select[6] ? prg_bank[0] : second_last[7:0];
         want.prg_map = {last_bank[7:0], slot2, prg_bank[1], slot0};

         pairs   = {8'(chr_bank[1] + 8'd1), chr_bank[1], 8'(chr_bank[0] + 8'd1), chr_bank[0]};
         singles = {chr_bank[5], chr_bank[4], chr_bank[3], chr_bank[2]};
         want.chr_map = bank_select[7] ? {pairs, singles} : {singles, pairs};

         want.mirror_horizontal = mirror;
         expected_maps.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_response(logic irq_pulse, logic mirror_horizontal,
                          logic [31:0] prg_map, logic [63:0] chr_map);
         bank_maps_type want;
         checked++;
         if (expected_maps.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = expected_maps.pop_front();
         if (irq_pulse !== want.irq_pulse)
            report_mismatch($sformatf("irq_pulse got %b want %b", irq_pulse, want.irq_pulse));
         if (mirror_horizontal !== want.mirror_horizontal)
            report_mismatch($sformatf("mirror_horizontal got %b want %b",
                                      mirror_horizontal, want.mirror_horizontal));
         if (prg_map !== want.prg_map)
            report_mismatch($sformatf("prg_map got %h want %h", prg_map, want.prg_map));
         if (chr_map !== want.chr_map)
            report_mismatch($sformatf("chr_map got %h want %h", chr_map, want.chr_map));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [15:0] req_addr;
   logic [7:0]  req_data;
   logic [8:0]  req_scanline;
   logic        req_render_on;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_irq_pulse;
   logic        rsp_mirror_horizontal;
   logic [31:0] rsp_prg_map;
   logic [63:0] rsp_chr_map;
   logic        csr_valid;
   logic        csr_ready;
   logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [8:0]  csr_data;

   bank_map_scoreboard_type sb = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   bank_switch_mapper_scanline_irq_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_addr              (req_addr),
      .req_data              (req_data),
      .req_scanline          (req_scanline),
      .req_render_on         (req_render_on),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_irq_pulse         (rsp_irq_pulse),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .rsp_prg_map           (rsp_prg_map),
      .rsp_chr_map           (rsp_chr_map),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog: give up on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check every response the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_irq_pulse, rsp_mirror_horizontal, rsp_prg_map, rsp_chr_map);
   end

   // -------------------------------------------------------------------------
   // Request helpers
   // -------------------------------------------------------------------------
   function automatic bsm_pkg::item_type make_request(logic mode, logic [15:0] addr,
                                                      logic [7:0] data,
                                                      logic [8:0] scanline,
                                                      logic render_on);
      bsm_pkg::item_type req;
      req.mode      = mode;
      req.addr      = addr;
      req.data      = data;
      req.scanline  = scanline;
      req.render_on = render_on;
      return req;
   endfunction

   function automatic bsm_pkg::item_type random_request();
      bsm_pkg::item_type req;
      logic [15:0]       code;
      int unsigned       pick;
      bit                small_data;

      req.mode      = bsm_pkg::MODE_WRITE;
      req.addr      = 16'($urandom);
      req.data      = 8'($urandom);
      req.scanline  = 9'($urandom);
      req.render_on = 1'($urandom);
      small_data    = 1'b0;
      pick          = $urandom_range(0, 99);

      if (pick < 45) begin
         // Keep most ticks on visible lines with rendering on so the counter runs
         req.mode = bsm_pkg::MODE_TICK;
         if ($urandom_range(0, 7) != 0) req.scanline  = 9'($urandom_range(0, 239));
         if ($urandom_range(0, 7) != 0) req.render_on = 1'b1;
      end else if (pick < 92) begin
         // Decoded write; scramble the ignored address bits
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:   code = bsm_pkg::ADDR_BANK_SELECT;
            6, 7, 8, 9, 10, 11: code = bsm_pkg::ADDR_BANK_DATA;
            12, 13:             code = bsm_pkg::ADDR_MIRROR;
            14:                 code = ADDR_MIRROR_NOP;
            15: begin code = bsm_pkg::ADDR_IRQ_COUNT;  small_data = 1'b1; end
            16: begin code = bsm_pkg::ADDR_IRQ_RELOAD; small_data = 1'b1; end
            17, 18:             code = bsm_pkg::ADDR_IRQ_ENABLE;
            default:            code = bsm_pkg::ADDR_IRQ_DISABLE;
         endcase
         req.addr = code | (req.addr & ~bsm_pkg::ADDR_MASK);
         // Short counts make the interrupt fire often
         if (small_data && $urandom_range(0, 3) != 0)
            req.data = 8'($urandom_range(0, 7));
      end
      // otherwise: stray write to any address, mostly undecoded

      return req;
   endfunction

   // Offer one request, hold it until accepted, then maybe idle between bursts
   task automatic send_request(input bsm_pkg::item_type req);
      int unsigned gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_mode      <= req.mode;
      req_addr      <= req.addr;
      req_data      <= req.data;
      req_scanline  <= req.scanline;
      req_render_on <= req.render_on;
      do @(posedge clock); while (!req_ready);
      sb.note_request(req);

      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // New burst: now and then a long one with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 15);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   endtask

   // Drop valid, drain every outstanding response, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_maps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_config(index, value);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Receiver: switch between stall styles in windows of random length, and
   // once hold off for a long stretch so the block backs up into the sender.
   // -------------------------------------------------------------------------
   initial begin
      rx_style_type style;
      int unsigned  window_left;
      int unsigned  hold_left;
      int unsigned  beat;
      bit           held_off;

      style       = RX_ALWAYS;
      window_left = 0;
      hold_left   = 0;
      beat        = 0;
      held_off    = 1'b0;
      rsp_ready   = 1'b0;

      forever begin
         @(negedge clock);
         if (!held_off && sb.checked >= HOLD_AFTER_RSP) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (window_left == 0) begin
               style       = rx_style_type'($urandom_range(0, 3));
               window_left = $urandom_range(8, 64);
            end
            window_left--;
            beat++;
            case (style)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom);
               RX_SPARSE: rsp_ready <= (beat % 4 == 0);
               default:   rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bsm_pkg::item_type directed_reqs [$];
      logic [8:0]        bank_count;
      logic              four_screen_on;
      int unsigned       phase;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = bsm_pkg::MODE_WRITE;
      req_addr      = 16'd0;
      req_data      = 8'd0;
      req_scanline  = 9'd0;
      req_render_on = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = bsm_pkg::CSR_PRG_BANK_COUNT;
      csr_data      = 9'd0;

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed opening on reset configuration.
      // Writes below the mapper window: ignored
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, 16'h0000, 8'hFF,
                                           9'd0, 1'b1));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, 16'h7FFF, 8'hFF,
                                           9'd511, 1'b0));
      // Program bank 0 with both swaps on, full-scale data
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_SELECT,
                                           {2'b11, 3'd0, bsm_pkg::SEL_PRG0}, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_DATA,
                                           8'hFF, 9'd0, 1'b0));
      // Character pair 1 via aliased addresses: odd bit drops, pair top lands on FF
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE,
                                           bsm_pkg::ADDR_BANK_SELECT | ALIAS_BITS,
                                           {5'd0, bsm_pkg::SEL_CHR1}, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE,
                                           bsm_pkg::ADDR_BANK_DATA | ALIAS_BITS,
                                           8'hFF, 9'd0, 1'b0));
      // Character pair 0 with character swap only
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_SELECT,
                                           {2'b10, 3'd0, bsm_pkg::SEL_CHR0}, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_DATA,
                                           8'h00, 9'd0, 1'b0));
      // Program bank 1 with program swap only
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_SELECT,
                                           {2'b01, 3'd0, bsm_pkg::SEL_PRG1}, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_DATA,
                                           8'h5A, 9'd0, 1'b0));
      // Last single character bank
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_SELECT,
                                           {5'd0, bsm_pkg::SEL_CHR5}, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_BANK_DATA,
                                           8'hFF, 9'd0, 1'b0));
      // Mirroring to horizontal, then the odd mirroring address that does nothing
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_MIRROR,
                                           8'hFF, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, ADDR_MIRROR_NOP | ALIAS_BITS,
                                           8'h00, 9'd0, 1'b0));
      // Counter 1, latch 2
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_IRQ_COUNT,
                                           8'h01, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE,
                                           bsm_pkg::ADDR_IRQ_RELOAD | ALIAS_BITS,
                                           8'h02, 9'd0, 1'b0));
      // Tick while IRQ disabled: no effect
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd0, 1'b1));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE,
                                           bsm_pkg::ADDR_IRQ_ENABLE | ALIAS_BITS,
                                           8'h00, 9'd0, 1'b0));
      // Tick off screen, then tick with rendering off: no effect
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'hFFFF, 8'hFF,
                                           9'd240, 1'b1));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd100, 1'b0));
      // Last visible line counts down to zero, next tick reloads and fires
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd239, 1'b1));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd0, 1'b1));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd511, 1'b1));
      // Disable, then a visible tick that must not count
      directed_reqs.push_back(make_request(bsm_pkg::MODE_WRITE, bsm_pkg::ADDR_IRQ_DISABLE,
                                           8'hFF, 9'd0, 1'b0));
      directed_reqs.push_back(make_request(bsm_pkg::MODE_TICK, 16'h0000, 8'h00,
                                           9'd0, 1'b1));

      foreach (directed_reqs[i]) send_request(directed_reqs[i]);

      // Random traffic, one configuration per phase
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            wait_idle();
            bank_count     = PHASE_BANK_COUNT[phase];
            four_screen_on = PHASE_FOUR_SCREEN[phase];
            if (phase == PHASE_COUNT - 1) begin
               bank_count     = 9'($urandom_range(3, 510));
               four_screen_on = 1'($urandom);
               // Unmapped index: must leave the mapper alone
               write_csr(CSR_UNUSED, 9'($urandom));
            end
            write_csr(bsm_pkg::CSR_PRG_BANK_COUNT, bank_count);
            write_csr(bsm_pkg::CSR_CHR_ROM_PRESENT, {8'd0, phase[0] == 1'b0});
            write_csr(bsm_pkg::CSR_FOUR_SCREEN, {8'd0, four_screen_on});
         end
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end

      // Drain and leave time for stray responses
      wait_idle();
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_maps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: bank_switch_mapper_scanline_irq_unit.f
hdl/bsm_pkg.sv
hdl/bsm_regs.sv
hdl/bsm_pack.sv
hdl/bank_switch_mapper_scanline_irq_unit.sv
dv/bank_switch_mapper_scanline_irq_unit_tb.sv
